// ===== rtl/core/kpq_pkg.sv =====
// ----------------------------------------------------------------------------
// kpq_pkg
// Shared types and constants for the keypad press qualifier.
// ----------------------------------------------------------------------------
package kpq_pkg;

  localparam int unsigned ScanW   = 8;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned CountW  = 4;

  // Bits 7 and 3 of each scan byte carry key state
  localparam logic [ScanW-1:0]  ScanBitPair      = 8'h88;
  // A lone bit 1 is never a legal key mask
  localparam logic [MaskW-1:0]  IllegalLoneMask  = 8'h02;
  localparam logic [CountW-1:0] StableReadsReset = 4'd3;

  // One input beat: four raw scan bytes
  typedef struct packed {
    logic [ScanW-1:0] scan_byte_0;
    logic [ScanW-1:0] scan_byte_1;
    logic [ScanW-1:0] scan_byte_2;
    logic [ScanW-1:0] scan_byte_3;
  } kpq_scan_t;

  // One output beat
  typedef struct packed {
    logic [MaskW-1:0] pressed_keys;
    logic             press_event;
  } kpq_result_t;

  // Packed key mask and its legality flag
  typedef struct packed {
    logic [MaskW-1:0] mask;
    logic             ok;
  } kpq_mask_t;

endpackage

// ===== rtl/core/kpq_scan_pack.sv =====
// ----------------------------------------------------------------------------
// kpq_scan_pack
// Folds four scan bytes into one key mask and flags legal masks.
// ----------------------------------------------------------------------------
module kpq_scan_pack (
  input  kpq_pkg::kpq_scan_t scan,
  output kpq_pkg::kpq_mask_t packed_mask
);

  logic [kpq_pkg::MaskW-1:0] mask;
  logic                      single_bit;

  // byte k contributes bits 7 and 3, shifted right by k
  assign mask = (scan.scan_byte_0 & kpq_pkg::ScanBitPair)
              | ((scan.scan_byte_1 & kpq_pkg::ScanBitPair) >> 1)
              | ((scan.scan_byte_2 & kpq_pkg::ScanBitPair) >> 2)
              | ((scan.scan_byte_3 & kpq_pkg::ScanBitPair) >> 3);

  // legal: no key, or exactly one key other than the lone bit 1
  assign single_bit = (mask != '0)
                   && ((mask & (mask - kpq_pkg::MaskW'(1))) == '0);

  assign packed_mask.mask = mask;
  assign packed_mask.ok   = (mask == '0)
                         || (single_bit && (mask != kpq_pkg::IllegalLoneMask));

endmodule

// ===== rtl/core/kpq_debounce.sv =====
// ----------------------------------------------------------------------------
// kpq_debounce
// Candidate / repeat-count debounce and press-from-idle detection.
// ----------------------------------------------------------------------------
module kpq_debounce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  kpq_pkg::kpq_mask_t         scan_mask,
  input  logic [kpq_pkg::CountW-1:0] stable_reads,
  output kpq_pkg::kpq_result_t       result
);

  logic [kpq_pkg::MaskW-1:0]  candidate_mask, candidate_mask_next;
  logic [kpq_pkg::CountW-1:0] repeat_count, repeat_count_next;
  logic [kpq_pkg::MaskW-1:0]  accepted_mask, accepted_mask_next;
  logic                       stable;

  // next debounce state and result for the beat in the input stage
  always_comb begin
    candidate_mask_next = candidate_mask;
    repeat_count_next   = repeat_count;
    accepted_mask_next  = accepted_mask;
    stable              = 1'b0;
    result              = '0;
    if (scan_mask.ok) begin
      if (scan_mask.mask != candidate_mask) begin
        candidate_mask_next = scan_mask.mask;
        repeat_count_next   = kpq_pkg::CountW'(1);
      end else if (repeat_count < stable_reads) begin
        repeat_count_next = repeat_count + kpq_pkg::CountW'(1);
      end
      stable = (repeat_count_next >= stable_reads);
      if (stable && (scan_mask.mask != accepted_mask)) begin
        accepted_mask_next = scan_mask.mask;
        // report only a press out of the all-released state
        if (accepted_mask == '0) begin
          result.pressed_keys = scan_mask.mask;
          result.press_event  = 1'b1;
        end
      end
    end
  end

  // state commits once per beat passed to the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_mask <= '0;
      repeat_count   <= '0;
      accepted_mask  <= '0;
    end else if (step) begin
      candidate_mask <= candidate_mask_next;
      repeat_count   <= repeat_count_next;
      accepted_mask  <= accepted_mask_next;
    end
  end

endmodule

// ===== rtl/core/keypad_press_qualifier.sv =====
// ----------------------------------------------------------------------------
// keypad_press_qualifier
// Debounces key-scan reads and reports new key presses seen from idle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one beat per scan
//   read: four raw bytes. Output channel (out_valid / out_stall / out_data)
//   gives exactly one beat per input beat, in order: the newly pressed key
//   mask and a press flag, both zero when nothing new is reported.
//   A beat passes two register stages: input stage, then result stage.
//   Throughput: one beat per cycle while out_stall is low; the debounce
//   state is read and updated in the single step between the input and
//   result registers. The stable_reads register (reset value 3) is written
//   through cfg_we / cfg_wdata; the user must do so only while the block
//   is idle, as the block itself does not enforce it. Reset (rst,
//   synchronous) empties both stages and clears the debounce state. When
//   out_stall and out_valid are high the result stage holds; one more beat
//   is taken into the input stage, after which in_stall rises.
// ----------------------------------------------------------------------------
module keypad_press_qualifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kpq_pkg::kpq_scan_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kpq_pkg::kpq_result_t       out_data,
  input  logic                       cfg_we,
  input  logic [kpq_pkg::CountW-1:0] cfg_wdata
);

  logic [kpq_pkg::CountW-1:0] stable_reads;
  kpq_pkg::kpq_mask_t         in_mask;
  kpq_pkg::kpq_mask_t         s1_mask;
  logic                       s1_valid;
  logic                       advance;
  logic                       step;
  kpq_pkg::kpq_result_t       result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_reads <= kpq_pkg::StableReadsReset;
    end else if (cfg_we) begin
      stable_reads <= cfg_wdata;
    end
  end

  kpq_scan_pack u_pack (
    .scan        (in_data),
    .packed_mask (in_mask)
  );

  // flow control: result stage moves when empty or not stalled
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = advance && s1_valid;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((advance || !s1_valid) && in_valid) begin
      s1_mask <= in_mask;
    end
  end

  kpq_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .scan_mask    (s1_mask),
    .stable_reads (stable_reads),
    .result       (result)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  // a reported press always carries exactly one key
  a_press_onehot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.press_event) |-> $onehot(out_data.pressed_keys))
    else $error("press reported without a single key");

  // no key mask without a press flag
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.press_event) |-> (out_data.pressed_keys == '0))
    else $error("key mask reported without press flag");

  // lone bit 1 is never reported
  a_no_lone_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pressed_keys != kpq_pkg::IllegalLoneMask))
    else $error("illegal lone key reported");

  // input stage can only block while the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_valid))
    else $error("input stalled without output backpressure");

  // both stages are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule
